@@ hw/rtl/ast_pkg.sv @@
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and codes for the addressed status table.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam logic [15:0] MFR_ID_STATUS  = 16'hFFFF;
  localparam logic [15:0] SERVICE_STATUS = 16'hABCD;
  localparam int unsigned CFG_BITS       = 32;

  typedef enum logic [1:0] {
    REG_CHANNEL_FILTER = 2'd0,
    REG_SELECTED_SLOT  = 2'd1,
    REG_TIMEOUT_MS     = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_ADVERT = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    EV_FOUND    = 3'd0,
    EV_UPDATED  = 3'd1,
    EV_LOST     = 3'd2,
    EV_REJECTED = 3'd3,
    EV_FULL     = 3'd4,
    EV_SWEEP    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    CMD_REJECT = 2'd0,
    CMD_ADVERT = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic              opcode;
    logic [31:0]       now_ms;
    logic [47:0]       adv_addr;
    logic [1:0]        adv_addr_type;
    logic signed [7:0] adv_rssi;
    logic              has_status;
    logic [15:0]       mfr_id;
    logic [15:0]       service_id;
    logic [7:0]        adv_channel;
    logic [63:0]       status_payload;
  } in_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [2:0]        slot;
    logic [47:0]       slot_addr;
    logic [1:0]        slot_addr_type;
    logic signed [7:0] slot_rssi;
    logic [63:0]       slot_payload;
    logic signed [3:0] display_slot;
    logic              last;
  } out_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] now_ms;
    logic [47:0] addr;
    logic [1:0]  addr_type;
    logic [7:0]  rssi;
    logic [63:0] payload;
  } cmd_t;

endpackage

@@ hw/rtl/ast_front.sv @@
// ----------------------------------------------------------------------------
// ast_front
// Accepts items, filters adverts and queues commands for the table engine.
// ----------------------------------------------------------------------------
module ast_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  ast_pkg::in_t  item,
  input  logic [7:0]    channel_filter,
  output logic          q_valid,
  output ast_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import ast_pkg::*;

  cmd_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push;
  logic       ok;

  assign item_stall = (count == 2'd2);
  assign push       = item_valid && !item_stall;
  assign q_valid    = (count != 2'd0);
  assign q_cmd      = fifo[rd_ptr];

  always_comb begin
    ok = item.has_status && (item.mfr_id == MFR_ID_STATUS) &&
         (item.service_id == SERVICE_STATUS) &&
         ((channel_filter == 8'd0) || (item.adv_channel == 8'd0) ||
          (channel_filter == item.adv_channel));
    cmd_in.now_ms    = item.now_ms;
    cmd_in.addr      = item.adv_addr;
    cmd_in.addr_type = item.adv_addr_type;
    cmd_in.rssi      = item.adv_rssi;
    cmd_in.payload   = item.status_payload;
    if (item.opcode == OP_TICK) begin
      cmd_in.kind = CMD_TICK;
    end else if (ok) begin
      cmd_in.kind = CMD_ADVERT;
    end else begin
      cmd_in.kind = CMD_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ hw/rtl/ast_back.sv @@
// ----------------------------------------------------------------------------
// ast_back
// Table engine: match and allocate, aging and newest-entry sweep, result emit.
// ----------------------------------------------------------------------------
module ast_back #(
  parameter int TABLE_SLOTS  = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  ast_pkg::cmd_t q_cmd,
  output logic          q_pop,
  input  logic [3:0]    selected_slot,
  input  logic [31:0]   timeout_ms,
  output logic          result_valid,
  input  logic          result_stall,
  output ast_pkg::out_t result
);
  import ast_pkg::*;

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_PICK  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                  state;
  logic [TABLE_SLOTS-1:0]  valid;
  logic [47:0]             e_addr [TABLE_SLOTS];
  logic [1:0]              e_type [TABLE_SLOTS];
  logic [31:0]             e_seen [TABLE_SLOTS];
  logic [7:0]              e_rssi [TABLE_SLOTS];
  logic [PAYLOAD_BITS-1:0] e_pay  [TABLE_SLOTS];

  logic [CW-1:0]          cnt;
  logic [TABLE_SLOTS-1:0] exp_mask;
  logic                   is_tick;
  logic [31:0]            now;
  event_t                 ev;
  logic [IW-1:0]          ev_idx;
  logic                   ev_with;
  logic                   best_v;
  logic [IW-1:0]          best;
  logic [31:0]            best_seen;
  logic [3:0]             disp;

  logic          hit_v, free_v;
  logic [IW-1:0] hit_idx, open_idx, wr_idx;
  logic          do_write;
  logic [IW-1:0] idx;
  logic          expire, stays;
  logic          sel_ok, sel_hit;
  logic          can_load;
  logic          load;
  logic [IW-1:0] emit_idx;

  always_comb begin
    hit_v    = 1'b0;
    free_v   = 1'b0;
    hit_idx  = '0;
    open_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (valid[i] && (e_addr[i] == q_cmd.addr)) begin
        hit_v   = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid[i]) begin
        free_v   = 1'b1;
        open_idx = IW'(i);
      end
    end
  end

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign do_write = q_pop && (q_cmd.kind == CMD_ADVERT) && (hit_v || free_v);
  assign wr_idx   = hit_v ? hit_idx : open_idx;

  assign idx    = cnt[IW-1:0];
  assign expire = is_tick && (timeout_ms != 32'd0) && valid[idx] &&
                  ((now - e_seen[idx]) > timeout_ms);
  assign stays  = valid[idx] && !expire;

  always_comb begin
    sel_ok  = !selected_slot[3] && (32'(selected_slot[2:0]) < TABLE_SLOTS);
    sel_hit = 1'b0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (sel_ok && (32'(selected_slot[2:0]) == i) && valid[i]) begin
        sel_hit = 1'b1;
      end
    end
  end

  assign can_load = !result_valid || !result_stall;
  assign load     = (state == S_EMIT) && can_load &&
                    (!is_tick || (cnt == CW'(TABLE_SLOTS)) || exp_mask[idx]);
  assign emit_idx = is_tick ? idx : ev_idx;

  always_ff @(posedge clk) begin
    if (do_write) begin
      e_addr[wr_idx] <= q_cmd.addr;
      e_type[wr_idx] <= q_cmd.addr_type;
      e_seen[wr_idx] <= q_cmd.now_ms;
      e_rssi[wr_idx] <= q_cmd.rssi;
      e_pay[wr_idx]  <= q_cmd.payload[PAYLOAD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid        <= '0;
      result_valid <= 1'b0;
      cnt          <= '0;
    end else begin
      if (result_valid && !result_stall && !load) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cnt       <= '0;
            exp_mask  <= '0;
            best_v    <= 1'b0;
            now       <= q_cmd.now_ms;
            is_tick   <= (q_cmd.kind == CMD_TICK);
            ev_idx    <= wr_idx;
            ev_with   <= 1'b0;
            state     <= S_SWEEP;
            case (q_cmd.kind)
              CMD_TICK:   ev <= EV_SWEEP;
              CMD_ADVERT: begin
                if (hit_v || free_v) begin
                  ev      <= hit_v ? EV_UPDATED : EV_FOUND;
                  ev_with <= 1'b1;
                  valid[wr_idx] <= 1'b1;
                end else begin
                  ev <= EV_FULL;
                end
              end
              default:    ev <= EV_REJECTED;
            endcase
          end
        end
        S_SWEEP: begin
          if (expire) begin
            valid[idx]    <= 1'b0;
            exp_mask[idx] <= 1'b1;
          end
          if (stays && (!best_v || (e_seen[idx] > best_seen))) begin
            best_v    <= 1'b1;
            best      <= idx;
            best_seen <= e_seen[idx];
          end
          if (cnt == CW'(TABLE_SLOTS - 1)) begin
            state <= S_PICK;
          end
          cnt <= cnt + 1'b1;
        end
        S_PICK: begin
          if (sel_hit) begin
            disp <= selected_slot;
          end else if (best_v) begin
            disp <= 4'(best);
          end else begin
            disp <= 4'hF;
          end
          cnt   <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (is_tick && (cnt != CW'(TABLE_SLOTS))) begin
            if (!exp_mask[idx]) begin
              cnt <= cnt + 1'b1;
            end else if (can_load) begin
              result_valid                <= 1'b1;
              result.event_res            <= EV_LOST;
              result.slot                 <= 3'(idx);
              result.slot_addr            <= e_addr[emit_idx];
              result.slot_addr_type       <= e_type[emit_idx];
              result.slot_rssi            <= e_rssi[emit_idx];
              result.slot_payload         <= 64'(e_pay[emit_idx]);
              result.display_slot         <= disp;
              result.last                 <= 1'b0;
              cnt                         <= cnt + 1'b1;
            end
          end else if (can_load) begin
            result_valid          <= 1'b1;
            result.event_res      <= ev;
            result.slot           <= ev_with ? 3'(ev_idx) : 3'd0;
            result.slot_addr      <= ev_with ? e_addr[emit_idx] : 48'd0;
            result.slot_addr_type <= ev_with ? e_type[emit_idx] : 2'd0;
            result.slot_rssi      <= ev_with ? e_rssi[emit_idx] : 8'd0;
            result.slot_payload   <= ev_with ? 64'(e_pay[emit_idx]) : 64'd0;
            result.display_slot   <= disp;
            result.last           <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/addressed_status_table_with_aging.sv @@
// ----------------------------------------------------------------------------
// addressed_status_table_with_aging
// Status advert table keyed by device address, with timeout aging.
// ----------------------------------------------------------------------------
// Items enter a two-deep command queue after the advert filter; the table
// engine then handles one item at a time. Each item passes through match
// and allocate, the aging and newest-entry sweep, which visits one slot
// per cycle, the display pick, and then its results (a tick also steps
// past each slot that did not expire); the results are held back by any
// output stall.
module addressed_status_table_with_aging #(
  parameter int TABLE_SLOTS  = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  ast_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output ast_pkg::out_t result,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import ast_pkg::*;

  logic [7:0]  channel_filter;
  logic [3:0]  selected_slot;
  logic [31:0] timeout_ms;
  logic        q_valid;
  logic        q_pop;
  cmd_t        q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_filter <= 8'd0;
      selected_slot  <= 4'hF;
      timeout_ms     <= 32'd30000;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CHANNEL_FILTER: channel_filter <= cfg_data[7:0];
        REG_SELECTED_SLOT:  selected_slot  <= cfg_data[3:0];
        REG_TIMEOUT_MS:     timeout_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  ast_front u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .channel_filter (channel_filter),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop)
  );

  ast_back #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .selected_slot (selected_slot),
    .timeout_ms    (timeout_ms),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

endmodule

@@ hw/rtl/ast_checker.sv @@
// ----------------------------------------------------------------------------
// ast_props
// Port-level checks for the addressed status table.
// ----------------------------------------------------------------------------
module ast_props (
  input logic          clk,
  input logic          rst,
  input logic          result_valid,
  input logic          result_stall,
  input ast_pkg::out_t result
);
  import ast_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last == (result.event_res != EV_LOST)))
    else $error("last flag does not match event");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.event_res == EV_REJECTED ||
    result.event_res == EV_FULL || result.event_res == EV_SWEEP)
    |-> result.slot == 3'd0 && result.slot_addr == 48'd0 &&
        result.slot_payload == 64'd0)
    else $error("slot data on event without slot");

endmodule

bind addressed_status_table_with_aging ast_props u_ast_props (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
